@@ rtl/bsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared sizes, codes and types of the banker's safety check block.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int MAX_RES     = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int PROC_W   = $clog2(MAX_PROCS);
  localparam int RES_W    = $clog2(MAX_RES);
  localparam int PCNT_W   = $clog2(MAX_PROCS + 1);
  localparam int RCNT_W   = $clog2(MAX_RES + 1);
  localparam int AVAIL_W  = COUNT_WIDTH + PCNT_W;
  localparam int ADDR_W   = PROC_W + RES_W;
  localparam int TBL_DEPTH = MAX_PROCS * MAX_RES;

  // fixed field widths of the channels
  localparam int ACTION_W  = 2;
  localparam int PFIELD_W  = 4;
  localparam int RFIELD_W  = 4;
  localparam int VALUE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_MAX   = 2'd0,
    ACT_WR_ALLOC = 2'd1,
    ACT_WR_AVAIL = 2'd2,
    ACT_RUN      = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_PROCS = 2'd0,
    REG_NUM_RES   = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   we_max;
    logic                   we_alloc;
    logic [ADDR_W-1:0]      addr;
    logic [COUNT_WIDTH-1:0] wdata;
  } tbl_req_t;

endpackage

@@ rtl/bsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_if
// Valid/ready channel interfaces of the banker's safety check block.
// ----------------------------------------------------------------------------
interface bsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsc_pkg::ACTION_W-1:0]  action;
  logic [bsc_pkg::PFIELD_W-1:0]  process;
  logic [bsc_pkg::RFIELD_W-1:0]  resource;
  logic [bsc_pkg::VALUE_W-1:0]   value;

  modport source(output valid, action, process, resource, value, input ready);
  modport sink(input valid, action, process, resource, value, output ready);
endinterface

interface bsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsc_pkg::PFIELD_W-1:0]  process_res;
  logic                          deadlocked;
  logic                          last;

  modport source(output valid, process_res, deadlocked, last, input ready);
  modport sink(input valid, process_res, deadlocked, last, output ready);
endinterface

interface bsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bsc_pkg::CFG_IDX_W-1:0] index;
  logic [bsc_pkg::CFG_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/bankers_safety_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety check over loaded demand and allocation tables.
// ----------------------------------------------------------------------------
// A write item (max, allocation or available entry) is taken while idle. A
// run item clears the finish flags and passes over the processes in ascending
// order until a pass grants nothing; the block is not ready while it runs.
// All work goes through one compare/add unit fed by a single table read port
// with registered data, so every resource step is a read state and then a
// compare or add state: checking a process walks its R resources until one
// fails, granting it walks them again, over at most N+1 passes (N processes).
// The results then leave at most one per cycle while the receiver takes them,
// a finished process passed over in the deadlocked list taking a step of its
// own: the safe order when every process finished, otherwise the deadlocked
// processes in ascending order, with last set on the final one. Available is
// updated in place and must be reloaded before the next run.
// ----------------------------------------------------------------------------
module bankers_safety_check (
  input  logic       clk,
  input  logic       rst_n,
  bsc_in_if.sink     in_ch,
  bsc_out_if.source  out_ch,
  bsc_cfg_if.sink    cfg_ch
);
  import bsc_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       cfg_np_r, cfg_nr_r;
  logic [PCNT_W-1:0]      n_r, n_nxt;
  logic [RCNT_W-1:0]      nres_r, nres_nxt;
  logic [PCNT_W-1:0]      i_r, i_nxt;
  logic [RES_W-1:0]       j_r, j_nxt;
  logic [PCNT_W-1:0]      k_r, k_nxt;
  logic [PCNT_W-1:0]      gc_r, gc_nxt;
  logic                   prog_r, prog_nxt;
  logic                   safe_r, safe_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [PROC_W-1:0]      out_proc_r, out_proc_nxt;
  logic                   out_dead_r, out_dead_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [AVAIL_W-1:0]     avail_r [MAX_RES];
  logic [PROC_W-1:0]      go_r [MAX_PROCS];
  logic [MAX_PROCS-1:0]   fin_r;

  tbl_req_t               tbl_req;
  logic [COUNT_WIDTH-1:0] max_q, alloc_q;

  logic                   avail_we;
  logic [RES_W-1:0]       avail_idx;
  logic [AVAIL_W-1:0]     avail_wdata;
  logic                   fin_clr, fin_set, go_we;
  logic                   in_ready;

  logic [COUNT_WIDTH:0]   need;
  logic                   fail;
  logic                   last_j;
  logic                   dead_last;
  logic                   slot_free;
  logic [PCNT_W-1:0]      n_clamp;
  logic [RCNT_W-1:0]      nres_clamp;

  bsc_tables u_tables (
    .clk     (clk),
    .req     (tbl_req),
    .max_q   (max_q),
    .alloc_q (alloc_q)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.process_res = out_proc_r;
  assign out_ch.deadlocked  = out_dead_r;
  assign out_ch.last        = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_np_r <= CFG_W'(1);
      cfg_nr_r <= CFG_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_NUM_PROCS: cfg_np_r <= cfg_ch.data;
        REG_NUM_RES:   cfg_nr_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above the table size as the table size
  always_comb begin
    if (cfg_np_r == '0) begin
      n_clamp = PCNT_W'(1);
    end else if (int'(cfg_np_r) > MAX_PROCS) begin
      n_clamp = PCNT_W'(MAX_PROCS);
    end else begin
      n_clamp = PCNT_W'(cfg_np_r);
    end
    if (cfg_nr_r == '0) begin
      nres_clamp = RCNT_W'(1);
    end else if (int'(cfg_nr_r) > MAX_RES) begin
      nres_clamp = RCNT_W'(MAX_RES);
    end else begin
      nres_clamp = RCNT_W'(cfg_nr_r);
    end
  end

  // signed need against available
  assign need   = {1'b0, max_q} - {1'b0, alloc_q};
  assign fail   = !need[COUNT_WIDTH] &&
                  (AVAIL_W'(need[COUNT_WIDTH-1:0]) > avail_r[j_r]);
  assign last_j = (RCNT_W'(j_r) == (nres_r - RCNT_W'(1)));

  // no unfinished process above k among those in use
  always_comb begin
    dead_last = 1'b1;
    for (int b = 0; b < MAX_PROCS; b++) begin
      if (!fin_r[b] && (PCNT_W'(b) > k_r) && (PCNT_W'(b) < n_r)) begin
        dead_last = 1'b0;
      end
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    nres_nxt      = nres_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    gc_nxt        = gc_r;
    prog_nxt      = prog_r;
    safe_nxt      = safe_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_proc_nxt  = out_proc_r;
    out_dead_nxt  = out_dead_r;
    out_last_nxt  = out_last_r;
    tbl_req.we_max   = 1'b0;
    tbl_req.we_alloc = 1'b0;
    tbl_req.addr     = {i_r[PROC_W-1:0], j_r};
    tbl_req.wdata    = in_ch.value[COUNT_WIDTH-1:0];
    avail_we    = 1'b0;
    avail_idx   = j_r;
    avail_wdata = avail_r[j_r] + AVAIL_W'(alloc_q);
    fin_clr     = 1'b0;
    fin_set     = 1'b0;
    go_we       = 1'b0;
    in_ready    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          tbl_req.addr = {in_ch.process, in_ch.resource};
          unique case (action_t'(in_ch.action))
            ACT_WR_MAX:   tbl_req.we_max = 1'b1;
            ACT_WR_ALLOC: tbl_req.we_alloc = 1'b1;
            ACT_WR_AVAIL: begin
              avail_we    = 1'b1;
              avail_idx   = in_ch.resource;
              avail_wdata = AVAIL_W'(in_ch.value[COUNT_WIDTH-1:0]);
            end
            ACT_RUN: begin
              n_nxt     = n_clamp;
              nres_nxt  = nres_clamp;
              fin_clr   = 1'b1;
              gc_nxt    = '0;
              i_nxt     = '0;
              prog_nxt  = 1'b0;
              state_nxt = ST_PROC;
            end
            default: ;
          endcase
        end
      end
      ST_PROC: begin
        if (i_r == n_r) begin
          if (prog_r) begin
            i_nxt    = '0;
            prog_nxt = 1'b0;
          end else begin
            safe_nxt  = (gc_r == n_r);
            k_nxt     = '0;
            state_nxt = ST_EMIT;
          end
        end else if (fin_r[i_r[PROC_W-1:0]]) begin
          i_nxt = i_r + PCNT_W'(1);
        end else begin
          j_nxt     = '0;
          state_nxt = ST_CHK_RD;
        end
      end
      ST_CHK_RD: state_nxt = ST_CHK_CMP;
      ST_CHK_CMP: begin
        if (fail) begin
          i_nxt     = i_r + PCNT_W'(1);
          state_nxt = ST_PROC;
        end else if (last_j) begin
          j_nxt     = '0;
          state_nxt = ST_ADD_RD;
        end else begin
          j_nxt     = j_r + RES_W'(1);
          state_nxt = ST_CHK_RD;
        end
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: begin
        avail_we = 1'b1;
        if (last_j) begin
          fin_set   = 1'b1;
          go_we     = 1'b1;
          gc_nxt    = gc_r + PCNT_W'(1);
          prog_nxt  = 1'b1;
          i_nxt     = i_r + PCNT_W'(1);
          state_nxt = ST_PROC;
        end else begin
          j_nxt     = j_r + RES_W'(1);
          state_nxt = ST_ADD_RD;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (safe_r) begin
            out_valid_nxt = 1'b1;
            out_proc_nxt  = go_r[k_r[PROC_W-1:0]];
            out_dead_nxt  = 1'b0;
            out_last_nxt  = (k_r == (n_r - PCNT_W'(1)));
            k_nxt         = k_r + PCNT_W'(1);
            if (k_r == (n_r - PCNT_W'(1))) begin
              state_nxt = ST_IDLE;
            end
          end else if (fin_r[k_r[PROC_W-1:0]]) begin
            k_nxt = k_r + PCNT_W'(1);
          end else begin
            out_valid_nxt = 1'b1;
            out_proc_nxt  = k_r[PROC_W-1:0];
            out_dead_nxt  = 1'b1;
            out_last_nxt  = dead_last;
            k_nxt         = k_r + PCNT_W'(1);
            if (dead_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gc_r        <= '0;
      prog_r      <= 1'b0;
      safe_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      n_r         <= PCNT_W'(1);
      nres_r      <= RCNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gc_r        <= gc_nxt;
      prog_r      <= prog_nxt;
      safe_r      <= safe_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      nres_r      <= nres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_proc_r <= out_proc_nxt;
    out_dead_r <= out_dead_nxt;
    out_last_r <= out_last_nxt;
    if (avail_we) begin
      avail_r[avail_idx] <= avail_wdata;
    end
    if (go_we) begin
      go_r[gc_r[PROC_W-1:0]] <= i_r[PROC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= '0;
    end else if (fin_clr) begin
      fin_r <= '0;
    end else if (fin_set) begin
      fin_r[i_r[PROC_W-1:0]] <= 1'b1;
    end
  end

endmodule

@@ rtl/bsc_tables.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_tables
// Maximum-demand and allocation tables, one shared address, registered read.
// ----------------------------------------------------------------------------
module bsc_tables (
  input  logic                            clk,
  input  bsc_pkg::tbl_req_t               req,
  output logic [bsc_pkg::COUNT_WIDTH-1:0] max_q,
  output logic [bsc_pkg::COUNT_WIDTH-1:0] alloc_q
);
  import bsc_pkg::*;

  logic [COUNT_WIDTH-1:0] max_mem   [TBL_DEPTH];
  logic [COUNT_WIDTH-1:0] alloc_mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we_max) begin
      max_mem[req.addr] <= req.wdata;
    end
    max_q <= max_mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (req.we_alloc) begin
      alloc_mem[req.addr] <= req.wdata;
    end
    alloc_q <= alloc_mem[req.addr];
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bankers_safety_check. Table and available loads
// and safety runs are driven in bursts on the input channel, and the result
// channel is stalled on shifting patterns. Every run is replayed on a
// behavioral copy of the block, and its grant order or deadlocked list is
// compared field by field with each result transfer, or a typed result
// where a directed row gives one. A short table of directed items comes
// first, then randomized load/run phases with register changes between them.
// ----------------------------------------------------------------------------
module tb;
  import bsc_pkg::*;

  localparam int          ITEM_TARGET  = 325;
  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam longint      AVAIL_CEIL   = 1_000_000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_ALTERNATE, SINK_SPARSE, SINK_CHOKE} sink_mode_t;

  typedef struct packed {
    action_t              act;
    logic [PFIELD_W-1:0]  proc;
    logic [RFIELD_W-1:0]  res;
    logic [VALUE_W-1:0]   val;
  } item_t;

  typedef struct packed {
    logic [PFIELD_W-1:0] proc;
    logic                dead;
    logic                last;
  } verdict_t;

  typedef struct packed {
    row_kind_t            kind;
    action_t              act;
    cfg_reg_t             ridx;
    logic [PFIELD_W-1:0]  proc;
    logic [RFIELD_W-1:0]  res;
    logic [VALUE_W-1:0]   val;     // entry count, or register data on a cfg row
    logic                 chk;     // expected single result typed in below
    logic [PFIELD_W-1:0]  x_proc;
    logic                 x_dead;
  } step_row_t;

  localparam step_row_t DIR_ROWS [27] = '{
    // one process, one resource, zero need against zero available
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_ALLOC, REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_AVAIL, REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_RUN,      REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b1, 4'd0, 1'b0},
    // need one above available
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_AVAIL, REG_NUM_PROCS, 4'd0, 4'd0, 16'hFFFE, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_RUN,      REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b1, 4'd0, 1'b1},
    // full allocation, zero need, available grows past 16 bits
    '{ROW_ITEM, ACT_WR_ALLOC, REG_NUM_PROCS, 4'd0, 4'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_RUN,      REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b1, 4'd0, 1'b0},
    // negative need, no reload of available
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_RUN,      REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b1, 4'd0, 1'b0},
    // two processes where the second must go first
    '{ROW_CFG,  ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd0, 16'd2,    1'b0, 4'd0, 1'b0},
    '{ROW_CFG,  ACT_WR_MAX,   REG_NUM_RES,   4'd0, 4'd0, 16'd2,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd0, 16'd5,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd1, 16'd5,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd1, 4'd0, 16'd2,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_MAX,   REG_NUM_PROCS, 4'd1, 4'd1, 16'd2,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_ALLOC, REG_NUM_PROCS, 4'd0, 4'd0, 16'd1,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_ALLOC, REG_NUM_PROCS, 4'd0, 4'd1, 16'd1,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_ALLOC, REG_NUM_PROCS, 4'd1, 4'd0, 16'd1,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_ALLOC, REG_NUM_PROCS, 4'd1, 4'd1, 16'd1,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_AVAIL, REG_NUM_PROCS, 4'd0, 4'd0, 16'd3,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_WR_AVAIL, REG_NUM_PROCS, 4'd0, 4'd1, 16'd3,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_RUN,      REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
    // zero in both registers reads as one
    '{ROW_CFG,  ACT_WR_MAX,   REG_NUM_PROCS, 4'd0, 4'd0, 16'd0,    1'b0, 4'd0, 1'b0},
    '{ROW_CFG,  ACT_WR_MAX,   REG_NUM_RES,   4'd0, 4'd0, 16'd0,    1'b0, 4'd0, 1'b0},
    '{ROW_ITEM, ACT_RUN,      REG_NUM_PROCS, 4'd0, 4'd0, 16'h0000, 1'b0, 4'd0, 1'b0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bsc_in_if  in_ch();
  bsc_out_if out_ch();
  bsc_cfg_if cfg_ch();

  bankers_safety_check u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block
  logic [CFG_W-1:0]       cfg_nproc = 5'd1;
  logic [CFG_W-1:0]       cfg_nres  = 5'd1;
  logic [VALUE_W-1:0]     dem_tbl [MAX_PROCS][MAX_RES];
  logic [VALUE_W-1:0]     alc_tbl [MAX_PROCS][MAX_RES];
  longint                 avail_vec [MAX_RES];
  bit                     dem_set [MAX_PROCS][MAX_RES];
  bit                     alc_set [MAX_PROCS][MAX_RES];
  bit                     avail_set [MAX_RES];

  verdict_t    verdict_q [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int unsigned cycle_cnt  = 0;

  logic        sink_ready = 1'b0;
  sink_mode_t  sink_mode  = SINK_OPEN;
  int          mode_left  = 0;

  assign out_ch.ready = sink_ready;

  function automatic int eff_count(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 16) return 16;
    return int'(raw);
  endfunction

  // one safety run on the shadow state; available is updated in place
  task automatic predict_safety_run(output verdict_t outs[$]);
    int       n;
    int       nr;
    int       last_dead;
    int       order [$];
    bit [15:0] done_f;
    bit       progress;
    bit       fits;
    verdict_t v;
    n = eff_count(cfg_nproc);
    nr = eff_count(cfg_nres);
    done_f = '0;
    outs = {};
    do begin
      progress = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!done_f[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++)
            if (longint'(dem_tbl[i][j]) - longint'(alc_tbl[i][j]) > avail_vec[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < nr; j++) avail_vec[j] += longint'(alc_tbl[i][j]);
            done_f[i] = 1'b1;
            progress = 1'b1;
            order.push_back(i);
          end
        end
      end
    end while (progress);
    if (order.size() == n) begin
      for (int k = 0; k < n; k++) begin
        v.proc = 4'(order[k]);
        v.dead = 1'b0;
        v.last = (k == n - 1);
        outs.push_back(v);
      end
    end else begin
      last_dead = 0;
      for (int i = 0; i < n; i++) if (!done_f[i]) last_dead = i;
      for (int i = 0; i < n; i++) begin
        if (!done_f[i]) begin
          v.proc = 4'(i);
          v.dead = 1'b1;
          v.last = (i == last_dead);
          outs.push_back(v);
        end
      end
    end
  endtask

  task automatic apply_item(input item_t it, input bit chk, input verdict_t typed_v);
    verdict_t outs [$];
    case (it.act)
      ACT_WR_MAX: begin
        dem_tbl[it.proc][it.res] = it.val;
        dem_set[it.proc][it.res] = 1'b1;
      end
      ACT_WR_ALLOC: begin
        alc_tbl[it.proc][it.res] = it.val;
        alc_set[it.proc][it.res] = 1'b1;
      end
      ACT_WR_AVAIL: begin
        avail_vec[it.res] = longint'(it.val);
        avail_set[it.res] = 1'b1;
      end
      default: begin
        predict_safety_run(outs);
        if (chk) verdict_q.push_back(typed_v);
        else foreach (outs[k]) verdict_q.push_back(outs[k]);
      end
    endcase
  endtask

  // valid stays up across a burst; gaps only between bursts
  task automatic send_item(input item_t it, input bit chk, input verdict_t typed_v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= it.act;
    in_ch.process  <= it.proc;
    in_ch.resource <= it.res;
    in_ch.value    <= it.val;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
    apply_item(it, chk, typed_v);
  endtask

  task automatic send_entry(input action_t act, input int p, input int r,
                            input logic [VALUE_W-1:0] v);
    item_t it;
    it.act = act;
    it.proc = 4'(p);
    it.res = 4'(r);
    it.val = v;
    send_item(it, 1'b0, '0);
  endtask

  // block idle: input quiet, all results in, run fully wound down
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg valid high; the caller drops it after the last write
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_NUM_PROCS) cfg_nproc = data;
    else if (idx == REG_NUM_RES) cfg_nres = data;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] gen_alloc();
    case ($urandom_range(0, 15))
      0:       return 16'($urandom);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  // mostly small positive need, sometimes zero or negative, sometimes wild
  function automatic logic [VALUE_W-1:0] gen_demand(logic [VALUE_W-1:0] a);
    int unsigned s;
    s = a + $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, a));
      default: return (s > 65535) ? 16'hFFFF : 16'(s);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] gen_avail();
    case ($urandom_range(0, 11))
      0:       return 16'($urandom);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic random_phase();
    logic [CFG_W-1:0]   pn;
    logic [CFG_W-1:0]   pr;
    logic [VALUE_W-1:0] a;
    int  n;
    int  nr;
    bit  retable;
    bit  reload;
    if ($urandom_range(0, 2) == 0) begin
      drain_block();
      pn = pick_size();
      pr = pick_size();
      // keep the slow corners narrow in the other dimension
      if (eff_count(pn) > 8 && eff_count(pr) > 3) pr = 5'($urandom_range(1, 3));
      if (eff_count(pr) > 8 && eff_count(pn) > 3) pn = 5'($urandom_range(1, 3));
      if ($urandom_range(0, 1)) begin
        reg_write(REG_NUM_PROCS, pn);
        reg_write(REG_NUM_RES, pr);
      end else begin
        reg_write(REG_NUM_RES, pr);
        reg_write(REG_NUM_PROCS, pn);
      end
      if ($urandom_range(0, 5) == 0)
        reg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 5'($urandom));
      cfg_ch.valid <= 1'b0;
    end
    n = eff_count(cfg_nproc);
    nr = eff_count(cfg_nres);
    retable = ($urandom_range(0, 2) != 0);
    for (int p = 0; p < n; p++) begin
      for (int r = 0; r < nr; r++) begin
        if (!dem_set[p][r] || !alc_set[p][r] || (retable && $urandom_range(0, 3) == 0)) begin
          a = gen_alloc();
          if ($urandom_range(0, 1)) begin
            send_entry(ACT_WR_ALLOC, p, r, a);
            send_entry(ACT_WR_MAX, p, r, gen_demand(a));
          end else begin
            send_entry(ACT_WR_MAX, p, r, gen_demand(a));
            send_entry(ACT_WR_ALLOC, p, r, a);
          end
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        send_entry(action_t'(2'($urandom_range(0, 2))), $urandom_range(0, 15),
                   $urandom_range(0, 15), 16'($urandom));
    end
    // a skipped reload reuses what the last run left in available
    reload = ($urandom_range(0, 4) != 0);
    for (int r = 0; r < nr; r++)
      if (reload || !avail_set[r] || avail_vec[r] > AVAIL_CEIL)
        send_entry(ACT_WR_AVAIL, 0, r, gen_avail());
    send_entry(ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
  endtask

  initial begin
    item_t     it;
    verdict_t  tv;
    step_row_t row;
    bit        cfg_open;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_WR_MAX;
    in_ch.process  = '0;
    in_ch.resource = '0;
    in_ch.value    = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_NUM_PROCS;
    cfg_ch.data    = '0;
    cfg_open       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < $size(DIR_ROWS); k++) begin
      row = DIR_ROWS[k];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) drain_block();
        reg_write(row.ridx, 5'(row.val));
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        it.act = row.act;
        it.proc = row.proc;
        it.res = row.res;
        it.val = row.val;
        tv.proc = row.x_proc;
        tv.dead = row.x_dead;
        tv.last = 1'b1;
        send_item(it, row.chk, tv);
      end
    end

    while (items_sent < ITEM_TARGET) random_phase();

    drain_block();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // receiver: stall pattern changes whenever its mode countdown runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode <= sink_mode_t'(2'($urandom_range(0, 3)));
      mode_left <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:      sink_ready <= 1'b1;
      SINK_ALTERNATE: sink_ready <= ~sink_ready;
      SINK_SPARSE:    sink_ready <= ($urandom_range(0, 3) == 0);
      default:        sink_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // each result transfer against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: process_res=%0d deadlocked=%0d last=%0d",
               out_ch.process_res, out_ch.deadlocked, out_ch.last);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.process_res !== want.proc) begin
          $error("process_res: expected %0d, got %0d", want.proc, out_ch.process_res);
          mismatches++;
        end
        if (out_ch.deadlocked !== want.dead) begin
          $error("deadlocked: expected %0d, got %0d", want.dead, out_ch.deadlocked);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

@@ bankers_safety_check.f @@
rtl/bsc_pkg.sv
rtl/bsc_if.sv
rtl/bsc_tables.sv
rtl/bankers_safety_check.sv
dv/tb.sv
